@@ rtl/palette_nearest_color_allocator_defines.svh @@
// Assertion macros for the palette allocator checker.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef PALETTE_NEAREST_COLOR_ALLOCATOR_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define PNCA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("palette allocator check failed");

// Next-cycle implication, held off during reset.
`define PNCA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("palette allocator check failed");

`endif

@@ rtl/pnca_pkg.sv @@
// Shared types and codes for the palette allocator.
// No dependencies.
`default_nettype none
package pnca_pkg;
    localparam int ENTRIES_DEF = 256;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;

    localparam logic [1:0] ST_EXACT = 2'd0;
    localparam logic [1:0] ST_FREE  = 2'd1;
    localparam logic [1:0] ST_NEAR  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic cap;      // capture request, arm scan
        logic clr;      // clear-pass write at scan counter
        logic rd_req;   // read entry at request index
        logic scan_rd;  // read entry at scan counter, advance
        logic commit;   // write back and load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_alloc;
        logic cnt_last;
        logic pipe_busy;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/pnca_ctrl.sv @@
// Sequencer for the palette allocator: clear pass, request dispatch, scan.
// Depends on pnca_pkg.
`default_nettype none
module pnca_ctrl import pnca_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.cnt_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = i_sts.is_alloc ? S_SCAN : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_req = 1'b1;
                n_state      = S_WR;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.cnt_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = S_WR;
            end
            S_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

@@ rtl/pnca_dp.sv @@
// Datapath for the palette allocator: colormap memories, scan pipeline,
// nearest/exact trackers, free count and result register. Depends on pnca_pkg.
`default_nettype none
module pnca_dp import pnca_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  wire  [1:0]  i_req_type,
    input  wire  [7:0]  i_pixel_index,
    input  wire  [7:0]  i_red_in,
    input  wire  [7:0]  i_green_in,
    input  wire  [7:0]  i_blue_in,
    input  wire         i_mark_used,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_pixel_out,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [1:0]  o_status,
    output logic [8:0]  o_free_count
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [23:0] col_mem  [ENTRIES];
    logic        used_mem [ENTRIES];

    // captured request
    logic [1:0]  r_req;
    logic [7:0]  r_idx;
    logic [23:0] r_want;
    logic        r_mark;

    logic [IW-1:0] r_cnt;
    logic [CW-1:0] r_free;

    // scan pipeline
    logic          r_v1, r_v2;
    logic [IW-1:0] r_i1, r_i2;
    logic [23:0]   r_q_col, r_c2;
    logic          r_q_used, r_u2, r_eq2;
    logic [15:0]   r_sq_r, r_sq_g, r_sq_b;

    // trackers
    logic          r_m_found, r_m_used, r_f_have, r_n_have;
    logic [IW-1:0] r_m_idx, r_f_idx, r_n_idx;
    logic [17:0]   r_f_d, r_n_d;
    logic [23:0]   r_n_col;

    logic          r_o_valid;

    logic [31:0]   idx_w;
    logic [IW-1:0] req_addr;
    logic          in_range;

    assign idx_w    = {24'd0, r_idx};
    assign req_addr = idx_w[IW-1:0];
    assign in_range = (idx_w < 32'(ENTRIES));

    assign o_sts.is_alloc  = (i_req_type == REQ_ALLOC);
    assign o_sts.cnt_last  = (r_cnt == IW'(ENTRIES - 1));
    assign o_sts.pipe_busy = r_v1 | r_v2;
    assign o_sts.out_free  = !r_o_valid || !i_stall;
    assign o_valid         = r_o_valid;

    // request capture and scan counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req  <= i_req_type;
            r_idx  <= i_pixel_index;
            r_want <= {i_red_in, i_green_in, i_blue_in};
            r_mark <= i_mark_used;
        end
        if (!i_rst_n || i_cmd.cap) r_cnt <= '0;
        else if (i_cmd.clr || i_cmd.scan_rd) r_cnt <= r_cnt + 1'b1;
    end

    // registered memory read; data holds until the next read command
    logic [IW-1:0] rd_addr;
    assign rd_addr = i_cmd.rd_req ? req_addr : r_cnt;
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_req || i_cmd.scan_rd) begin
            r_q_col  <= col_mem[rd_addr];
            r_q_used <= used_mem[rd_addr];
        end
        r_i1 <= r_cnt;
    end

    // squared component distances
    logic signed [8:0]  dr, dg, db;
    logic signed [17:0] pr, pg, pb;
    always_comb begin
        dr = $signed({1'b0, r_q_col[23:16]}) - $signed({1'b0, r_want[23:16]});
        dg = $signed({1'b0, r_q_col[15:8]})  - $signed({1'b0, r_want[15:8]});
        db = $signed({1'b0, r_q_col[7:0]})   - $signed({1'b0, r_want[7:0]});
        pr = dr * dr;
        pg = dg * dg;
        pb = db * db;
    end
    always_ff @(posedge i_clk) begin
        r_sq_r <= pr[15:0];
        r_sq_g <= pg[15:0];
        r_sq_b <= pb[15:0];
        r_i2   <= r_i1;
        r_c2   <= r_q_col;
        r_u2   <= r_q_used;
        r_eq2  <= (r_q_col == r_want);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_rd;
            r_v2 <= r_v1;
        end
    end

    // exact, nearest-free and nearest-overall trackers
    logic [17:0] dsum;
    assign dsum = {2'b00, r_sq_r} + {2'b00, r_sq_g} + {2'b00, r_sq_b};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cap) begin
            r_m_found <= 1'b0;
            r_f_have  <= 1'b0;
            r_n_have  <= 1'b0;
        end else if (r_v2) begin
            if (r_eq2 && !r_m_found) begin
                r_m_found <= 1'b1;
                r_m_idx   <= r_i2;
                r_m_used  <= r_u2;
            end
            if (!r_u2 && (!r_f_have || dsum < r_f_d)) begin
                r_f_have <= 1'b1;
                r_f_idx  <= r_i2;
                r_f_d    <= dsum;
            end
            if (!r_n_have || dsum < r_n_d) begin
                r_n_have <= 1'b1;
                r_n_idx  <= r_i2;
                r_n_d    <= dsum;
                r_n_col  <= r_c2;
            end
        end
    end

    // commit: write-back and result
    logic          wr_col, wr_used, take;
    logic [IW-1:0] wa, pix;
    logic [23:0]   res_col;
    logic [1:0]    res_st;
    logic [CW-1:0] n_free;
    logic [31:0]   pix_w, free_w;
    always_comb begin
        wr_col  = 1'b0;
        wr_used = 1'b0;
        take    = 1'b0;
        wa      = req_addr;
        pix     = req_addr;
        res_col = 24'd0;
        res_st  = ST_DONE;
        if (r_req == REQ_LOAD) begin
            if (in_range) begin
                wr_col  = 1'b1;
                wr_used = r_mark;
                take    = r_mark && !r_q_used;
                res_col = r_want;
            end
        end else if (r_req == REQ_ALLOC) begin
            if (r_m_found) begin
                wa      = r_m_idx;
                pix     = r_m_idx;
                wr_used = 1'b1;
                take    = !r_m_used;
                res_col = r_want;
                res_st  = ST_EXACT;
            end else if (r_f_have) begin
                wa      = r_f_idx;
                pix     = r_f_idx;
                wr_col  = 1'b1;
                wr_used = 1'b1;
                take    = 1'b1;
                res_col = r_want;
                res_st  = ST_FREE;
            end else begin
                pix     = r_n_idx;
                res_col = r_n_col;
                res_st  = ST_NEAR;
            end
        end else if (in_range) begin
            res_col = r_q_col;
        end
        n_free = (take && r_free != '0) ? r_free - 1'b1 : r_free;
        pix_w  = 32'(pix);
        free_w = 32'(n_free);
    end

    // memory write port, shared by clear pass and commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            col_mem[r_cnt]  <= 24'd0;
            used_mem[r_cnt] <= 1'b0;
        end else if (i_cmd.commit) begin
            if (wr_col)  col_mem[wa]  <= r_want;
            if (wr_used) used_mem[wa] <= 1'b1;
        end
    end

    // free count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= CW'(ENTRIES);
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_free    <= n_free;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        if (i_cmd.commit) begin
            o_pixel_out  <= (r_req == REQ_ALLOC) ? pix_w[7:0] : r_idx;
            o_red_out    <= res_col[23:16];
            o_green_out  <= res_col[15:8];
            o_blue_out   <= res_col[7:0];
            o_status     <= res_st;
            o_free_count <= free_w[8:0];
        end
    end
endmodule
`default_nettype wire

@@ rtl/palette_nearest_color_allocator.sv @@
// Palette allocator with exact / nearest-color allocation over a writable colormap.
// A request returns one result. After reset a clearing pass over all ENTRIES entries
// runs with o_stall high. Load and lookup read the indexed entry, then commit;
// allocate scans one colormap entry per cycle through the single memory read port,
// then drains the two-stage distance pipeline before commit. The write-back waits
// while the previous result is still stalled on o_valid. One request is in work at a
// time; a new one may be accepted while the previous result still waits on o_valid.
// Depends on pnca_pkg, pnca_ctrl, pnca_dp.
`default_nettype none
module palette_nearest_color_allocator import pnca_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [1:0] i_req_type,
    input  wire  [7:0] i_pixel_index,
    input  wire  [7:0] i_red_in,
    input  wire  [7:0] i_green_in,
    input  wire  [7:0] i_blue_in,
    input  wire        i_mark_used,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_pixel_out,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out,
    output logic [1:0] o_status,
    output logic [8:0] o_free_count
);
    t_cmd cmd;
    t_sts sts;

    pnca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pnca_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_pixel_index (i_pixel_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_mark_used   (i_mark_used),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_out   (o_pixel_out),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_status      (o_status),
        .o_free_count  (o_free_count)
    );
endmodule
`default_nettype wire

@@ rtl/pnca_chk.sv @@
// Port-level checker for the palette allocator, bound to the top level.
// Depends on pnca_pkg and palette_nearest_color_allocator_defines.svh.
`default_nettype none
`include "palette_nearest_color_allocator_defines.svh"
module pnca_chk import pnca_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_stall,
    input wire       o_valid,
    input wire       i_stall,
    input wire [7:0] o_pixel_out,
    input wire [1:0] o_status,
    input wire [8:0] o_free_count
);
    // a stalled result holds
    `PNCA_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_pixel_out))
    // accepting a transaction makes the block busy
    `PNCA_ASSERT_NXT(a_busy, i_valid && !o_stall, o_stall)
    // nearest-overall only when nothing is free
    `PNCA_ASSERT_NOW(a_full, o_valid && o_status == ST_NEAR, o_free_count == 9'd0)
    // clearing pass runs right after reset
    `PNCA_ASSERT_NOW(a_clr, $rose(i_rst_n), o_stall)
endmodule

bind palette_nearest_color_allocator pnca_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_pixel_out  (o_pixel_out),
    .o_status     (o_status),
    .o_free_count (o_free_count)
);
`default_nettype wire
